// ===== hw/rtl/stereo_voice_mixer_agc_pcm_macros.svh =====
// ----------------------------------------------------------------------------
// stereo voice mixer assertion macros
// shared concurrent assertion forms for the mixer rtl
// ----------------------------------------------------------------------------
`ifndef STEREO_VOICE_MIXER_AGC_PCM_MACROS_SVH
`define STEREO_VOICE_MIXER_AGC_PCM_MACROS_SVH

// condition implies consequence in the same cycle
`define SVM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("svm assertion failed");

// condition implies consequence in the next cycle
`define SVM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("svm assertion failed");

`endif

// ===== hw/rtl/svm_pkg.sv =====
// ----------------------------------------------------------------------------
// svm_pkg
// types, constants and helpers shared by the stereo voice mixer
// ----------------------------------------------------------------------------
package svm_pkg;

   localparam int MAX_FRAMES = 64;
   localparam int MAX_VOICES = 16;

   localparam int FRAME_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int VOICE_W = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
   localparam int FCNT_W  = $clog2(MAX_FRAMES + 1);
   localparam int VCNT_W  = $clog2(MAX_VOICES + 1);

   localparam int SAMPLE_W   = 16;
   localparam int PCM_W      = 16;
   localparam int SUM_W      = 20;
   localparam int GAIN_W     = 17;
   localparam int VOICES_CFG_W = 5;
   localparam int FRAMES_CFG_W = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   localparam int G_W     = 33;   // product of two gains, up to 2^32
   localparam int G_LO_W  = 17;
   localparam int MUL_A_W = 20;
   localparam int MUL_B_W = 17;
   localparam int MUL_W   = MUL_A_W + MUL_B_W;
   localparam int PP_W    = MUL_W + G_LO_W;
   localparam int PP10_W  = PP_W + 4;

   localparam int DIV_W   = 31;
   localparam int DVS_W   = 21;
   localparam int DCNT_W  = $clog2(DIV_W + 1);

   localparam logic [GAIN_W-1:0]  GAIN_ONE   = GAIN_W'(65536);
   localparam logic [DIV_W-1:0]   SCALE_NUM  = DIV_W'(58982 * 32768);
   localparam logic [PP10_W-1:0]  AGC_THRESH = PP10_W'(9) << 47;
   localparam logic [MUL_B_W-1:0] PCM_FULL   = MUL_B_W'(32767);
   localparam logic [DIV_W-1:0]   PCM_NEG_LIM = DIV_W'(32768);
   localparam logic [DIV_W-1:0]   PCM_POS_LIM = DIV_W'(32767);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MASTER_GAIN    = 3'd0,
      CSR_MIX_GAIN_LEFT  = 3'd1,
      CSR_MIX_GAIN_RIGHT = 3'd2,
      CSR_AGC_ENABLE     = 3'd3,
      CSR_RECORD_ENABLE  = 3'd4,
      CSR_ACTIVE_VOICES  = 3'd5,
      CSR_BLOCK_FRAMES   = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic [GAIN_W-1:0]       master_gain;
      logic [GAIN_W-1:0]       mix_gain_left;
      logic [GAIN_W-1:0]       mix_gain_right;
      logic                    agc_enable;
      logic                    record_enable;
      logic [VOICES_CFG_W-1:0] active_voices;
      logic [FRAMES_CFG_W-1:0] block_frames;
   } cfg_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] voice_left;
      logic signed [SAMPLE_W-1:0] voice_right;
      logic [FRAME_W-1:0]         frame_idx;
      logic                       first_voice;
      logic                       frame_end;
      logic                       block_end;
   } item_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_ACC, ST_GL, ST_GR, ST_GW,
      ST_PK0, ST_PK1, ST_PK2, ST_PKDIV,
      ST_ERD, ST_E0, ST_E1, ST_E2, ST_E3, ST_E3B, ST_E4, ST_E5, ST_EDIV, ST_EOUT
   } back_state_type;

   function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] g);
      return (g > GAIN_ONE) ? GAIN_ONE : g;
   endfunction

   function automatic logic [VCNT_W-1:0] eff_voices(input logic [VOICES_CFG_W-1:0] v);
      logic [VCNT_W-1:0] r;
      if (v == '0) r = VCNT_W'(1);
      else if (int'(v) > MAX_VOICES) r = VCNT_W'(MAX_VOICES);
      else r = VCNT_W'(v);
      return r;
   endfunction

   function automatic logic [FCNT_W-1:0] eff_frames(input logic [FRAMES_CFG_W-1:0] f);
      logic [FCNT_W-1:0] r;
      if (f == '0) r = FCNT_W'(1);
      else if (int'(f) > MAX_FRAMES) r = FCNT_W'(MAX_FRAMES);
      else r = FCNT_W'(f);
      return r;
   endfunction

endpackage

// ===== hw/rtl/stereo_voice_mixer_agc_pcm.sv =====
// ----------------------------------------------------------------------------
// stereo_voice_mixer_agc_pcm
// stereo voice mixer with block peak agc and 16-bit pcm output
// ----------------------------------------------------------------------------
//
//  channel  ports   direction  transaction
//  req      req_*   in         one voice's stereo sample, frame-major
//  rsp      rsp_*   out        one pcm frame of a finished block
//  csr      csr_*   in         one register write, index and data
//
// in the back end a sample is a frame store read, then an accumulate and
// write; the two-entry queue lets the front keep taking samples
// meanwhile
// at block end the agc pass forms the channel gains and scales each peak,
// running the serial divider for a limited channel; each emitted frame then
// uses the shared multiplier and a serial divide by the voice count
// synchronous active-high reset; the frame store has no reset and needs none
// a stalled rsp holds the back end; req stalls only when the queue is full
//
module stereo_voice_mixer_agc_pcm
   import svm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_voice_left,
   input  logic signed [SAMPLE_W-1:0] req_voice_right,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [PCM_W-1:0]    rsp_pcm_left,
   output logic signed [PCM_W-1:0]    rsp_pcm_right,
   output logic                       rsp_last_frame,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data
);

`include "stereo_voice_mixer_agc_pcm_macros.svh"

   cfg_type  cfg_ff;
   logic     q_push, q_full, q_pop, q_valid;
   item_type push_item, head_item;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.master_gain    <= GAIN_W'(32768);
         cfg_ff.mix_gain_left  <= GAIN_W'(32768);
         cfg_ff.mix_gain_right <= GAIN_W'(32768);
         cfg_ff.agc_enable     <= 1'b1;
         cfg_ff.record_enable  <= 1'b0;
         cfg_ff.active_voices  <= VOICES_CFG_W'(1);
         cfg_ff.block_frames   <= FRAMES_CFG_W'(64);
      end else if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_MASTER_GAIN:    cfg_ff.master_gain    <= csr_data[GAIN_W-1:0];
            CSR_MIX_GAIN_LEFT:  cfg_ff.mix_gain_left  <= csr_data[GAIN_W-1:0];
            CSR_MIX_GAIN_RIGHT: cfg_ff.mix_gain_right <= csr_data[GAIN_W-1:0];
            CSR_AGC_ENABLE:     cfg_ff.agc_enable     <= csr_data[0];
            CSR_RECORD_ENABLE:  cfg_ff.record_enable  <= csr_data[0];
            CSR_ACTIVE_VOICES:  cfg_ff.active_voices  <= csr_data[VOICES_CFG_W-1:0];
            CSR_BLOCK_FRAMES:   cfg_ff.block_frames   <= csr_data[FRAMES_CFG_W-1:0];
            default: ;  // writes past the register list are dropped
         endcase
      end
   end

   // front: classify samples by voice and frame position
   svm_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_voice_left  (req_voice_left),
      .req_voice_right (req_voice_right),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_item          (push_item)
   );

   // decoupling queue
   svm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (head_item)
   );

   // back: accumulate, agc, emit
   svm_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_valid        (q_valid),
      .q_item         (head_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pcm_left   (rsp_pcm_left),
      .rsp_pcm_right  (rsp_pcm_right),
      .rsp_last_frame (rsp_last_frame)
   );

   // queue never written when full, never read when empty
   `SVM_ASSERT_IMPL(a_queue_no_overflow, clock, reset, q_push, !q_full)
   `SVM_ASSERT_IMPL(a_queue_no_underflow, clock, reset, q_pop, q_valid)
   // a sample taken while the queue is empty makes it non-empty next cycle
   `SVM_ASSERT_NEXT(a_queue_fills, clock, reset, q_push && !q_valid, q_valid)

endmodule

// ===== hw/rtl/svm_front.sv =====
// ----------------------------------------------------------------------------
// svm_front
// accepts voice samples and tags each with frame position and block end
// ----------------------------------------------------------------------------
module svm_front
   import svm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  cfg_type                    cfg,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_voice_left,
   input  logic signed [SAMPLE_W-1:0] req_voice_right,
   input  logic                       q_full,
   output logic                       q_push,
   output item_type                   q_item
);

   logic [VOICE_W-1:0] voice_cnt_ff, voice_cnt_in;
   logic [FRAME_W-1:0] frame_cnt_ff, frame_cnt_in;
   logic [VCNT_W-1:0]  voices;
   logic [FCNT_W-1:0]  frames;
   logic               frame_end, block_end;

   assign voices    = eff_voices(cfg.active_voices);
   assign frames    = eff_frames(cfg.block_frames);
   assign frame_end = (VCNT_W'(voice_cnt_ff) + VCNT_W'(1)) >= voices;
   assign block_end = frame_end && ((FCNT_W'(frame_cnt_ff) + FCNT_W'(1)) >= frames);

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_item.voice_left  = req_voice_left;
      q_item.voice_right = req_voice_right;
      q_item.frame_idx   = frame_cnt_ff;
      q_item.first_voice = (voice_cnt_ff == '0);
      q_item.frame_end   = frame_end;
      q_item.block_end   = block_end;
   end

   always_comb begin
      voice_cnt_in = voice_cnt_ff;
      frame_cnt_in = frame_cnt_ff;
      if (q_push) begin
         if (!frame_end) begin
            voice_cnt_in = voice_cnt_ff + VOICE_W'(1);
         end else begin
            voice_cnt_in = '0;
            frame_cnt_in = block_end ? '0 : frame_cnt_ff + FRAME_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         voice_cnt_ff <= '0;
         frame_cnt_ff <= '0;
      end else begin
         voice_cnt_ff <= voice_cnt_in;
         frame_cnt_ff <= frame_cnt_in;
      end
   end

endmodule

// ===== hw/rtl/svm_queue.sv =====
// ----------------------------------------------------------------------------
// svm_queue
// two-entry queue of tagged samples between front and back
// ----------------------------------------------------------------------------
module svm_queue
   import svm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     valid,
   output item_type head
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign valid = (count_ff != 2'd0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hw/rtl/svm_div.sv =====
// ----------------------------------------------------------------------------
// svm_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module svm_div
   import svm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff;
   logic [DCNT_W-1:0] cnt_ff;
   logic              busy_ff, done_ff;
   logic [DVS_W:0]    shifted, trial;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      trial   = shifted - {1'b0, dvs_ff};
      if (shifted >= {1'b0, dvs_ff}) begin
         rem_in = trial[DVS_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], 1'b1};
      end else begin
         rem_in = shifted[DVS_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], 1'b0};
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DCNT_W'(DIV_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - DCNT_W'(1);
            if (cnt_ff == DCNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         quo_ff <= req.dividend;
         rem_ff <= '0;
         dvs_ff <= req.divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

endmodule

// ===== hw/rtl/svm_back.sv =====
// ----------------------------------------------------------------------------
// svm_back
// frame store accumulation, block peak agc and pcm emission sequencer
// ----------------------------------------------------------------------------
module svm_back
   import svm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  logic                    q_valid,
   input  item_type                q_item,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [PCM_W-1:0] rsp_pcm_left,
   output logic signed [PCM_W-1:0] rsp_pcm_right,
   output logic                    rsp_last_frame
);

   back_state_type state_ff, state_in;

   // frame store
   logic signed [SUM_W-1:0] sum_l_mem [MAX_FRAMES];
   logic signed [SUM_W-1:0] sum_r_mem [MAX_FRAMES];
   logic signed [SUM_W-1:0] rd_l_ff, rd_r_ff;
   logic                    rd_en;
   logic [FRAME_W-1:0]      rd_addr;
   logic                    wr_en;

   logic [SUM_W-1:0]   peak_l_ff, peak_r_ff, blk_pk_l_ff, blk_pk_r_ff;
   logic [G_W-1:0]     gl_ff, gr_ff;
   logic [MUL_W-1:0]   mul_ff;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [MUL_W-1:0]   lo_ff;
   logic               ch_ff;
   logic               lim_l_ff, lim_r_ff;
   logic [MUL_B_W-1:0] scale_l_ff, scale_r_ff;
   logic [MUL_A_W-1:0] m_ff;
   logic [FCNT_W-1:0]  nframes_ff;
   logic [FRAME_W-1:0] k_ff;
   logic [PCM_W-1:0]   pcm_l_ff, pcm_r_ff;
   logic               rsp_valid_ff;
   logic [PCM_W-1:0]   rsp_l_ff, rsp_r_ff;
   logic               rsp_last_ff;

   div_req_type div_req;
   div_rsp_type div_rsp;

   // accumulate helpers
   logic signed [SUM_W:0]   add_l, add_r;
   logic signed [SUM_W-1:0] new_l, new_r;
   logic [SUM_W-1:0]        mag_new_l, mag_new_r;

   // agc and pcm helpers
   logic [G_W-1:0]     g_sel;
   logic [SUM_W-1:0]   peak_sel, mag_rd;
   logic signed [SUM_W-1:0] rd_sel;
   logic               lim_sel;
   logic [MUL_B_W-1:0] scale_sel;
   logic [PP_W-1:0]    pp;
   logic [PP10_W-1:0]  pp10;
   logic [DVS_W-1:0]   pm;
   logic               lim_hit;
   logic [VCNT_W-1:0]  voices;
   logic [PCM_W-1:0]   pcm_val;
   logic [DIV_W-1:0]   p_sat;
   logic               last_k, out_free;

   function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] v);
      logic signed [SUM_W-1:0] r;
      if (v[SUM_W] != v[SUM_W-1]) r = v[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                              : {1'b0, {(SUM_W-1){1'b1}}};
      else r = v[SUM_W-1:0];
      return r;
   endfunction

   function automatic logic [SUM_W-1:0] mag_sum(input logic signed [SUM_W-1:0] v);
      return v[SUM_W-1] ? (~v + SUM_W'(1)) : v;
   endfunction

   svm_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      add_l     = (SUM_W+1)'(rd_l_ff) + (SUM_W+1)'(q_item.voice_left);
      add_r     = (SUM_W+1)'(rd_r_ff) + (SUM_W+1)'(q_item.voice_right);
      new_l     = q_item.first_voice ? SUM_W'(q_item.voice_left) : sat_sum(add_l);
      new_r     = q_item.first_voice ? SUM_W'(q_item.voice_right) : sat_sum(add_r);
      mag_new_l = mag_sum(new_l);
      mag_new_r = mag_sum(new_r);
   end

   always_comb begin
      g_sel     = ch_ff ? gr_ff : gl_ff;
      peak_sel  = ch_ff ? blk_pk_r_ff : blk_pk_l_ff;
      rd_sel    = ch_ff ? rd_r_ff : rd_l_ff;
      lim_sel   = ch_ff ? lim_r_ff : lim_l_ff;
      scale_sel = ch_ff ? scale_r_ff : scale_l_ff;
      mag_rd    = mag_sum(rd_sel);
      pp        = (PP_W'(mul_ff) << G_LO_W) + PP_W'(lo_ff);
      pp10      = (PP10_W'(pp) << 3) + (PP10_W'(pp) << 1);
      pm        = pp[32 +: DVS_W];
      lim_hit   = cfg.agc_enable && (pp10 > AGC_THRESH) && (pm != '0);
      voices    = eff_voices(cfg.active_voices);
      last_k    = (FCNT_W'(k_ff) + FCNT_W'(1)) == nframes_ff;
      out_free  = !rsp_valid_ff || rsp_ready;
      // pcm sign and saturation
      if (rd_sel[SUM_W-1]) begin
         p_sat   = (div_rsp.quotient > PCM_NEG_LIM) ? PCM_NEG_LIM : div_rsp.quotient;
         pcm_val = PCM_W'(~p_sat + DIV_W'(1));
      end else begin
         p_sat   = (div_rsp.quotient > PCM_POS_LIM) ? PCM_POS_LIM : div_rsp.quotient;
         pcm_val = PCM_W'(p_sat);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (q_valid) state_in = ST_ACC;
         ST_ACC:   state_in = q_item.block_end ? ST_GL : ST_IDLE;
         ST_GL:    state_in = ST_GR;
         ST_GR:    state_in = ST_GW;
         ST_GW:    state_in = ST_PK0;
         ST_PK0:   state_in = ST_PK1;
         ST_PK1:   state_in = ST_PK2;
         ST_PK2: begin
            if (lim_hit) state_in = ST_PKDIV;
            else if (!ch_ff) state_in = ST_PK0;
            else state_in = cfg.record_enable ? ST_ERD : ST_IDLE;
         end
         ST_PKDIV: begin
            if (div_rsp.done) begin
               if (!ch_ff) state_in = ST_PK0;
               else state_in = cfg.record_enable ? ST_ERD : ST_IDLE;
            end
         end
         ST_ERD:   state_in = ST_E0;
         ST_E0:    state_in = ST_E1;
         ST_E1:    state_in = ST_E2;
         ST_E2:    state_in = lim_sel ? ST_E3 : ST_E4;
         ST_E3:    state_in = ST_E3B;
         ST_E3B:   state_in = ST_E4;
         ST_E4:    state_in = ST_E5;
         ST_E5:    state_in = ST_EDIV;
         ST_EDIV:  if (div_rsp.done) state_in = ch_ff ? ST_EOUT : ST_E0;
         ST_EOUT:  if (out_free) state_in = last_k ? ST_IDLE : ST_ERD;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath controls
   always_comb begin
      q_pop            = 1'b0;
      rd_en            = 1'b0;
      rd_addr          = q_item.frame_idx;
      wr_en            = 1'b0;
      mul_a            = '0;
      mul_b            = '0;
      div_req.start    = 1'b0;
      div_req.dividend = SCALE_NUM;
      div_req.divisor  = pm;
      unique case (state_ff)
         ST_IDLE: rd_en = q_valid;
         ST_ACC: begin
            wr_en = 1'b1;
            q_pop = 1'b1;
         end
         ST_GL: begin
            mul_a = MUL_A_W'(clamp_gain(cfg.master_gain));
            mul_b = clamp_gain(cfg.mix_gain_left);
         end
         ST_GR: begin
            mul_a = MUL_A_W'(clamp_gain(cfg.master_gain));
            mul_b = clamp_gain(cfg.mix_gain_right);
         end
         ST_PK0: begin
            mul_a = peak_sel;
            mul_b = g_sel[G_LO_W-1:0];
         end
         ST_PK1: begin
            mul_a = peak_sel;
            mul_b = MUL_B_W'(g_sel[G_W-1:G_LO_W]);
         end
         ST_PK2: div_req.start = lim_hit;
         ST_ERD: begin
            rd_en   = 1'b1;
            rd_addr = k_ff;
         end
         ST_E0: begin
            mul_a = mag_rd;
            mul_b = g_sel[G_LO_W-1:0];
         end
         ST_E1: begin
            mul_a = mag_rd;
            mul_b = MUL_B_W'(g_sel[G_W-1:G_LO_W]);
         end
         ST_E3: begin
            mul_a = m_ff;
            mul_b = scale_sel;
         end
         ST_E4: begin
            mul_a = m_ff;
            mul_b = PCM_FULL;
         end
         ST_E5: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(mul_ff[MUL_W-1:15]);
            div_req.divisor  = DVS_W'(voices);
         end
         default: ;
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pcm_left   = rsp_l_ff;
   assign rsp_pcm_right  = rsp_r_ff;
   assign rsp_last_frame = rsp_last_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         peak_l_ff    <= '0;
         peak_r_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         ch_ff        <= 1'b0;
         k_ff         <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_ACC && q_item.frame_end) begin
            if (q_item.block_end) begin
               peak_l_ff <= '0;
               peak_r_ff <= '0;
            end else begin
               if (mag_new_l > peak_l_ff) peak_l_ff <= mag_new_l;
               if (mag_new_r > peak_r_ff) peak_r_ff <= mag_new_r;
            end
         end
         if (state_ff == ST_EOUT && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_GW:    ch_ff <= 1'b0;
            ST_PK2:   if (!lim_hit) ch_ff <= 1'b1;
            ST_PKDIV: if (div_rsp.done) ch_ff <= 1'b1;
            ST_ERD:   ch_ff <= 1'b0;
            ST_EDIV:  if (div_rsp.done) ch_ff <= 1'b1;
            ST_EOUT: begin
               if (out_free) begin
                  k_ff <= last_k ? '0 : k_ff + FRAME_W'(1);
               end
            end
            default: ;
         endcase
         if (state_ff == ST_PK2 && !ch_ff && !lim_hit) k_ff <= '0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mul_ff <= MUL_W'(mul_a) * MUL_W'(mul_b);
      if (rd_en) begin
         rd_l_ff <= sum_l_mem[rd_addr];
         rd_r_ff <= sum_r_mem[rd_addr];
      end
      if (wr_en) begin
         sum_l_mem[q_item.frame_idx] <= new_l;
         sum_r_mem[q_item.frame_idx] <= new_r;
      end
      unique case (state_ff)
         ST_ACC: begin
            if (q_item.block_end) begin
               blk_pk_l_ff <= (mag_new_l > peak_l_ff) ? mag_new_l : peak_l_ff;
               blk_pk_r_ff <= (mag_new_r > peak_r_ff) ? mag_new_r : peak_r_ff;
               nframes_ff  <= FCNT_W'(q_item.frame_idx) + FCNT_W'(1);
            end
         end
         ST_GR:  gl_ff <= mul_ff[G_W-1:0];
         ST_GW:  gr_ff <= mul_ff[G_W-1:0];
         ST_PK1: lo_ff <= mul_ff;
         ST_PK2: begin
            if (ch_ff) lim_r_ff <= lim_hit;
            else lim_l_ff <= lim_hit;
         end
         ST_PKDIV: begin
            if (div_rsp.done) begin
               if (ch_ff) scale_r_ff <= div_rsp.quotient[MUL_B_W-1:0];
               else scale_l_ff <= div_rsp.quotient[MUL_B_W-1:0];
            end
         end
         ST_E1:  lo_ff <= mul_ff;
         ST_E2:  m_ff <= pp[32 +: MUL_A_W];
         ST_E3B: m_ff <= mul_ff[16 +: MUL_A_W];
         ST_EDIV: begin
            if (div_rsp.done) begin
               if (ch_ff) pcm_r_ff <= pcm_val;
               else pcm_l_ff <= pcm_val;
            end
         end
         ST_EOUT: begin
            if (out_free) begin
               rsp_l_ff    <= pcm_l_ff;
               rsp_r_ff    <= pcm_r_ff;
               rsp_last_ff <= last_k;
            end
         end
         default: ;
      endcase
   end

endmodule

// ===== bench/tb_stereo_voice_mixer_agc_pcm.sv =====
// ----------------------------------------------------------------------------
// tb_stereo_voice_mixer_agc_pcm
// self-checking bench for the stereo voice mixer: a clocked driver feeds voice
// samples from a queue, a clocked monitor checks every pcm frame against a
// built-in mixer model, registers are rewritten between phases
// ----------------------------------------------------------------------------
module tb_stereo_voice_mixer_agc_pcm;
   import svm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
   } voice_sample_type;

   typedef struct {
      logic signed [PCM_W-1:0] left;
      logic signed [PCM_W-1:0] right;
      logic                    last;
   } pcm_frame_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_voice_left = '0;
   logic signed [SAMPLE_W-1:0] req_voice_right = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [PCM_W-1:0]    rsp_pcm_left;
   logic signed [PCM_W-1:0]    rsp_pcm_right;
   logic                       rsp_last_frame;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_data = '0;

   voice_sample_type pending_samples[$];
   pcm_frame_type    expected_frames[$];
   int               error_count = 0;
   int               sample_total = 0;
   bit               send_gaps = 1'b1;
   bit               recv_stalls = 1'b1;

   // model copy of the registers
   logic [GAIN_W-1:0]       m_master, m_gain_l, m_gain_r;
   logic                    m_agc, m_record;
   logic [VOICES_CFG_W-1:0] m_voices;
   logic [FRAMES_CFG_W-1:0] m_frames;

   // model copy of the mixer state
   int          frame_sum_l[MAX_FRAMES];
   int          frame_sum_r[MAX_FRAMES];
   int unsigned peak_l, peak_r, voice_pos, frame_pos;

   stereo_voice_mixer_agc_pcm i_dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model
   function automatic int sat_sum(int v);
      if (v > 524287) return 524287;
      if (v < -524288) return -524288;
      return v;
   endfunction

   function automatic int unsigned magnitude(int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic longint unsigned gain_clip(logic [GAIN_W-1:0] g);
      return (g > 65536) ? 64'd65536 : 64'(g);
   endfunction

   // limiter: returns 1 and the q1.16 scale when the mixed peak exceeds 0.9
   function automatic bit limit_scale(int unsigned peak, longint unsigned g,
                                      output longint unsigned scale);
      longint unsigned pm;
      scale = 0;
      if (!m_agc) return 0;
      if (64'(peak) * g * 10 <= 64'd9 << 47) return 0;
      pm = (64'(peak) * g) >> 32;
      if (pm == 0) return 0;
      scale = (64'd58982 * 64'd32768) / pm;
      return 1;
   endfunction

   function automatic logic [PCM_W-1:0] pcm_value(int raw, longint unsigned g, bit lim,
                                                  longint unsigned scale,
                                                  int unsigned voices);
      longint unsigned m, p;
      m = (64'(magnitude(raw)) * g) >> 32;
      if (lim) m = (m * scale) >> 16;
      p = (m * 32767) / (64'd32768 * voices);
      if (raw < 0) begin
         if (p > 32768) p = 32768;
         return PCM_W'(64'h10000 - p);
      end
      if (p > 32767) p = 32767;
      return PCM_W'(p);
   endfunction

   // accumulate one accepted sample, queue the block's frames at block end if recording is enabled
   task automatic mix_sample(voice_sample_type s);
      int unsigned f, voices, frames;
      longint unsigned gm, gl, gr, sl, sr;
      bit lim_l, lim_r;
      pcm_frame_type pf;
      f = frame_pos % MAX_FRAMES;
      voices = (m_voices == 0) ? 1 : (m_voices > MAX_VOICES) ? MAX_VOICES : m_voices;
      frames = (m_frames == 0) ? 1 : (m_frames > MAX_FRAMES) ? MAX_FRAMES : m_frames;
      if (voice_pos == 0) begin
         frame_sum_l[f] = s.left;
         frame_sum_r[f] = s.right;
      end else begin
         frame_sum_l[f] = sat_sum(frame_sum_l[f] + s.left);
         frame_sum_r[f] = sat_sum(frame_sum_r[f] + s.right);
      end
      if (voice_pos + 1 < voices) begin
         voice_pos++;
         return;
      end
      voice_pos = 0;
      if (magnitude(frame_sum_l[f]) > peak_l) peak_l = magnitude(frame_sum_l[f]);
      if (magnitude(frame_sum_r[f]) > peak_r) peak_r = magnitude(frame_sum_r[f]);
      if (f + 1 < frames) begin
         frame_pos = f + 1;
         return;
      end
      gm = gain_clip(m_master);
      gl = gm * gain_clip(m_gain_l);
      gr = gm * gain_clip(m_gain_r);
      lim_l = limit_scale(peak_l, gl, sl);
      lim_r = limit_scale(peak_r, gr, sr);
      frame_pos = 0;
      peak_l = 0;
      peak_r = 0;
      if (!m_record) return;
      for (int k = 0; k <= f; k++) begin
         pf.left  = pcm_value(frame_sum_l[k], gl, lim_l, sl, voices);
         pf.right = pcm_value(frame_sum_r[k], gr, lim_r, sr, voices);
         pf.last  = (k == f);
         expected_frames.push_back(pf);
      end
   endtask

   // ---------------------------------------------------------------- driver
   int send_wait = 0;
   always @(posedge clock) begin
      logic nv;
      voice_sample_type s;
      nv = req_valid;
      if (reset) begin
         nv = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            s.left  = req_voice_left;
            s.right = req_voice_right;
            mix_sample(s);
            nv = 1'b0;
            send_wait = send_gaps ? $urandom_range(0, 19) : 0;
         end
         if (!nv) begin
            if (send_wait > 0) begin
               send_wait--;
            end else if (pending_samples.size() > 0) begin
               s = pending_samples.pop_front();
               req_voice_left  <= s.left;
               req_voice_right <= s.right;
               nv = 1'b1;
            end
         end
      end
      req_valid <= nv;
   end

   // ---------------------------------------------------------------- monitor
   int recv_wait = 0;
   always @(posedge clock) begin
      pcm_frame_type e;
      logic nr;
      nr = rsp_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_frames.size() == 0) begin
               $error("unexpected pcm frame %0d %0d", rsp_pcm_left, rsp_pcm_right);
               error_count++;
            end else begin
               e = expected_frames.pop_front();
               if (rsp_pcm_left !== e.left) begin
                  $error("pcm_left expected %0d actual %0d", e.left, rsp_pcm_left);
                  error_count++;
               end
               if (rsp_pcm_right !== e.right) begin
                  $error("pcm_right expected %0d actual %0d", e.right, rsp_pcm_right);
                  error_count++;
               end
               if (rsp_last_frame !== e.last) begin
                  $error("last_frame expected %0d actual %0d", e.last, rsp_last_frame);
                  error_count++;
               end
            end
            recv_wait = recv_stalls ? $urandom_range(0, 19) : 0;
         end
         if (recv_wait > 0) begin
            recv_wait--;
            nr = 1'b0;
         end else begin
            nr = 1'b1;
         end
      end
      rsp_ready <= nr;
   end

   // ---------------------------------------------------------------- watchdog
   int cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 2000000) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus
   task automatic write_reg(csr_idx_type idx, int unsigned value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MASTER_GAIN:    m_master = GAIN_W'(value);
         CSR_MIX_GAIN_LEFT:  m_gain_l = GAIN_W'(value);
         CSR_MIX_GAIN_RIGHT: m_gain_r = GAIN_W'(value);
         CSR_AGC_ENABLE:     m_agc    = value[0];
         CSR_RECORD_ENABLE:  m_record = value[0];
         CSR_ACTIVE_VOICES:  m_voices = VOICES_CFG_W'(value);
         CSR_BLOCK_FRAMES:   m_frames = FRAMES_CFG_W'(value);
         default: ;
      endcase
   endtask

   task automatic set_regs(int unsigned mg, int unsigned gl, int unsigned gr,
                           int unsigned agc, int unsigned rec,
                           int unsigned voices, int unsigned frames);
      write_reg(CSR_MASTER_GAIN, mg);
      write_reg(CSR_MIX_GAIN_LEFT, gl);
      write_reg(CSR_MIX_GAIN_RIGHT, gr);
      write_reg(CSR_AGC_ENABLE, agc);
      write_reg(CSR_RECORD_ENABLE, rec);
      write_reg(CSR_ACTIVE_VOICES, voices);
      write_reg(CSR_BLOCK_FRAMES, frames);
   endtask

   task automatic add_sample(int l, int r);
      voice_sample_type s;
      s.left  = SAMPLE_W'(l);
      s.right = SAMPLE_W'(r);
      pending_samples.push_back(s);
      sample_total++;
   endtask

   // drain: all samples sent, all frames checked, then let the back end settle
   task automatic drain();
      while (pending_samples.size() > 0 || req_valid || expected_frames.size() > 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function automatic int pick_sample();
      case ($urandom_range(0, 7))
         0: return 32767;
         1: return -32768;
         default: return $signed(16'($urandom));
      endcase
   endfunction

   function automatic int unsigned pick_gain();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 65536;
         2: return 131071;
         default: return $urandom_range(0, 65536);
      endcase
   endfunction

   initial begin
      int unsigned v, fr, ev, ef, n;
      m_master = 32768; m_gain_l = 32768; m_gain_r = 32768;
      m_agc = 1; m_record = 0; m_voices = 1; m_frames = 64;
      peak_l = 0; peak_r = 0; voice_pos = 0; frame_pos = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // full-scale extremes, left limited by the agc, right gain zero
      set_regs(65536, 65536, 0, 1, 1, 1, 4);
      add_sample(32767, -32768);
      add_sample(-32768, 32767);
      add_sample(0, -1);
      add_sample(1, 0);
      drain();

      // gains above one, sixteen voices summing to the edge of the sum range
      set_regs(131071, 131071, 131071, 1, 1, 16, 1);
      for (int i = 0; i < 16; i++) add_sample(32767, -32768);
      drain();

      // zero voice and frame settings act as one, agc off
      set_regs(65536, 40000, 65536, 0, 1, 0, 0);
      add_sample(32767, -32768);
      add_sample(-12345, 23456);
      drain();

      // oversized settings with recording off, then a mid-block shrink
      set_regs(32768, 32768, 32768, 1, 0, 31, 127);
      add_sample(100, -100);
      add_sample(-32768, 32767);
      add_sample(5, 7);
      drain();
      write_reg(CSR_ACTIVE_VOICES, 1);
      write_reg(CSR_BLOCK_FRAMES, 1);
      write_reg(CSR_RECORD_ENABLE, 1);
      add_sample(-1, 1);
      drain();

      // random phases, mostly whole blocks with random content
      while (sample_total < 170) begin
         v  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4);
         fr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 8);
         ev = (v == 0) ? 1 : (v > MAX_VOICES) ? MAX_VOICES : v;
         ef = (fr == 0) ? 1 : (fr > MAX_FRAMES) ? MAX_FRAMES : fr;
         if (ev * ef > 64) begin
            v = 1;
            ev = 1;
         end
         send_gaps   = $urandom_range(0, 3) != 0;
         recv_stalls = $urandom_range(0, 3) != 0;
         set_regs(pick_gain(), pick_gain(), pick_gain(), $urandom_range(0, 1),
                  $urandom_range(0, 4) != 0, v, fr);
         n = ev * ef * $urandom_range(1, 2);
         if ($urandom_range(0, 3) == 0) n += $urandom_range(1, 3);
         for (int i = 0; i < n; i++) add_sample(pick_sample(), pick_sample());
         drain();
      end

      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/svm_pkg.sv
hw/rtl/svm_front.sv
hw/rtl/svm_queue.sv
hw/rtl/svm_div.sv
hw/rtl/svm_back.sv
hw/rtl/stereo_voice_mixer_agc_pcm.sv
bench/tb_stereo_voice_mixer_agc_pcm.sv
